// ===== rtl/core/tcp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants of the text command parser: keyword table,
// command codes, character codes and the per-byte step control struct.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int unsigned KW_COUNT   = 6;
  localparam int unsigned KW_MAX_LEN = 10;
  localparam int unsigned PROG_W     = 4;
  localparam int unsigned ACC_W      = 17;
  localparam int unsigned VALUE_W    = 16;

  localparam logic [ACC_W-1:0] ACC_MAX = 17'h1FFFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_END   = 8'h21;  // '!'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'd100;

  // Unused tail entries are never compared: progress always stays below length.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"O", "p", "e", "n", "V", "a", "l", "v", "e", CH_NUL},
    '{"C", "l", "o", "s", "e", "V", "a", "l", "v", "e"},
    '{"G", "e", "t", "L", "e", "v", "e", "l", CH_NUL, CH_NUL},
    '{"C", "o", "m", "m", "T", "e", "s", "t", CH_NUL, CH_NUL},
    '{"S", "e", "t", "M", "a", "x", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"S", "t", "a", "r", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
  };

  localparam logic [PROG_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd9, 4'd10, 4'd8, 4'd8, 4'd6, 4'd5
  };

  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_OPEN_VALVE = 3'd1,
    CMD_CLOSE_VALVE = 3'd2,
    CMD_GET_LEVEL  = 3'd3,
    CMD_COMM_TEST  = 3'd4,
    CMD_SET_MAX    = 3'd5,
    CMD_START      = 3'd6
  } cmd_code_e;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_e;

  // One processed byte: en = apply byte to state, clr = end of command.
  typedef struct packed {
    logic       en;
    logic       clr;
    logic [7:0] ch;
  } tcp_step_t;

endpackage

// ===== rtl/core/tcp_kw_bank.sv =====
// ----------------------------------------------------------------------------
// tcp_kw_bank
// Six keyword matchers side by side, plus the found flags and the stop flag
// set by a zero byte.
// ----------------------------------------------------------------------------
module tcp_kw_bank (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcp_pkg::tcp_step_t           step_i,
  output logic [tcp_pkg::KW_COUNT-1:0] found_o
);
  import tcp_pkg::*;

  logic [PROG_W-1:0]   prog_q [KW_COUNT];
  logic [PROG_W-1:0]   prog_d [KW_COUNT];
  logic [KW_COUNT-1:0] found_q, found_d;
  logic                stop_q, stop_d;

  always_comb begin
    logic [PROG_W-1:0] p;
    p       = '0;
    found_d = found_q;
    stop_d  = stop_q;
    for (int k = 0; k < KW_COUNT; k++) begin
      prog_d[k] = prog_q[k];
    end
    if (step_i.clr) begin
      found_d = '0;
      stop_d  = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        prog_d[k] = '0;
      end
    end else if (step_i.en) begin
      if (step_i.ch == CH_NUL) begin
        stop_d = 1'b1;
      end else if (!stop_q) begin
        for (int k = 0; k < KW_COUNT; k++) begin
          p = (prog_q[k] >= KW_LEN[k]) ? '0 : prog_q[k];
          if (KW_TEXT[k][p] == step_i.ch) begin
            if (p + 4'd1 == KW_LEN[k]) begin
              found_d[k] = 1'b1;
              prog_d[k]  = '0;
            end else begin
              prog_d[k] = p + 4'd1;
            end
          end else begin
            // first letter never recurs inside a keyword
            prog_d[k] = (KW_TEXT[k][0] == step_i.ch) ? 4'd1 : 4'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
      stop_q  <= 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        prog_q[k] <= '0;
      end
    end else begin
      found_q <= found_d;
      stop_q  <= stop_d;
      for (int k = 0; k < KW_COUNT; k++) begin
        prog_q[k] <= prog_d[k];
      end
    end
  end

  assign found_o = found_q;

endmodule

// ===== rtl/core/tcp_num_reader.sv =====
// ----------------------------------------------------------------------------
// tcp_num_reader
// Decimal value reader that starts after the first '#': skips whitespace,
// takes one optional sign, accumulates digits with saturation.
// ----------------------------------------------------------------------------
module tcp_num_reader (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tcp_pkg::tcp_step_t        step_i,
  output logic                      hash_seen_o,
  output logic                      negative_o,
  output logic [tcp_pkg::ACC_W-1:0] acc_o
);
  import tcp_pkg::*;

  num_phase_e        phase_q, phase_d;
  logic              hash_q, hash_d;
  logic              neg_q, neg_d;
  logic [ACC_W-1:0]  acc_q, acc_d;

  logic              is_digit, is_space, is_sign;
  logic [ACC_W+3:0]  acc_next;

  assign is_digit = (step_i.ch >= CH_ZERO) && (step_i.ch <= CH_NINE);
  assign is_space = (step_i.ch == CH_SPACE) || ((step_i.ch >= CH_TAB) && (step_i.ch <= CH_CR));
  assign is_sign  = (step_i.ch == CH_PLUS) || (step_i.ch == CH_MINUS);

  // acc * 10 + digit, widened so saturation sees the true sum
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {{(ACC_W){1'b0}}, step_i.ch[3:0]};

  // next-state logic
  always_comb begin
    phase_d = phase_q;
    hash_d  = hash_q;
    if (step_i.clr) begin
      phase_d = NUM_SKIP;
      hash_d  = 1'b0;
    end else if (step_i.en) begin
      if (!hash_q) begin
        hash_d = (step_i.ch == CH_HASH);
      end else begin
        unique case (phase_q)
          NUM_SKIP: begin
            if (is_sign || is_digit) begin
              phase_d = NUM_DIGITS;
            end else if (!is_space) begin
              phase_d = NUM_DONE;
            end
          end
          NUM_DIGITS: begin
            if (!is_digit) begin
              phase_d = NUM_DONE;
            end
          end
          NUM_DONE: phase_d = NUM_DONE;
          default:  phase_d = NUM_DONE;
        endcase
      end
    end
  end

  // datapath
  always_comb begin
    neg_d = neg_q;
    acc_d = acc_q;
    if (step_i.clr) begin
      neg_d = 1'b0;
      acc_d = '0;
    end else if (step_i.en && hash_q) begin
      if (phase_q == NUM_SKIP && is_sign) begin
        neg_d = (step_i.ch == CH_MINUS);
      end else if ((phase_q == NUM_SKIP || phase_q == NUM_DIGITS) && is_digit) begin
        acc_d = (acc_next > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_next[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= NUM_SKIP;
      hash_q  <= 1'b0;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hash_q  <= hash_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
    end
  end

  assign hash_seen_o = hash_q;
  assign negative_o  = neg_q;
  assign acc_o       = acc_q;

endmodule

// ===== rtl/core/text_command_parser_unit.sv =====
// ----------------------------------------------------------------------------
// text_command_parser_unit
// Byte-wise text command parser: keyword matchers and a decimal value reader,
// one command code and clamped value emitted per '!'.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; a byte is held in the input register only
// while a '!' waits for a stalled result slot. The input register feeds a
// single pass of matcher and accumulator logic into the matcher state; a
// '!' from the input register loads the result register from that state.
// Reset clears all command state and sets the limit to 100.
// ----------------------------------------------------------------------------
module text_command_parser_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command bytes
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  byte_in_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  command_code_o,
  output logic [tcp_pkg::VALUE_W-1:0] command_value_o,
  // value limit register
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcp_pkg::VALUE_W-1:0] cfg_value_limit_i
);
  import tcp_pkg::*;

  logic                in_valid_q;
  logic [7:0]          byte_q;
  logic                in_accept, fire, is_end;

  logic [VALUE_W-1:0]  limit_q;

  logic                out_valid_q;
  cmd_code_e           code_q, code_d;
  logic [VALUE_W-1:0]  value_q, value_d;

  tcp_step_t           step;
  logic [KW_COUNT-1:0] found;
  logic                hash_seen, negative;
  logic [ACC_W-1:0]    acc;

  assign is_end = (byte_q == CH_END);
  // only '!' needs the result slot
  assign fire      = in_valid_q && (!is_end || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= byte_in_i;
    end
  end

  assign step.en  = fire && !is_end;
  assign step.clr = fire && is_end;
  assign step.ch  = byte_q;

  tcp_kw_bank u_kw_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .found_o (found)
  );

  tcp_num_reader u_num_reader (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .hash_seen_o (hash_seen),
    .negative_o  (negative),
    .acc_o       (acc)
  );

  always_comb begin
    priority if (found[0]) code_d = CMD_OPEN_VALVE;
    else if (found[1])     code_d = CMD_CLOSE_VALVE;
    else if (found[2])     code_d = CMD_GET_LEVEL;
    else if (found[3])     code_d = CMD_COMM_TEST;
    else if (found[4])     code_d = CMD_SET_MAX;
    else if (found[5])     code_d = CMD_START;
    else                   code_d = CMD_NONE;
  end

  always_comb begin
    value_d = '0;
    if ((code_d == CMD_OPEN_VALVE || code_d == CMD_CLOSE_VALVE || code_d == CMD_SET_MAX)
        && hash_seen && !negative) begin
      value_d = (acc > {1'b0, limit_q}) ? limit_q : acc[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step.clr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.clr) begin
      code_q  <= code_d;
      value_q <= value_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_value_limit_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_code_o  = code_q;
  assign command_value_o = value_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_end_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.clr |=> out_valid_q)
    else $error("end of command did not load a result");

  a_value_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.clr |=> (command_value_o <= $past(limit_q)))
    else $error("result value above limit");

  a_value_zero_for_others: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && code_q != CMD_OPEN_VALVE && code_q != CMD_CLOSE_VALVE
     && code_q != CMD_SET_MAX) |-> (value_q == '0))
    else $error("nonzero value for a code without value");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.clr |=> (found == '0 && !hash_seen && acc == '0))
    else $error("command state not cleared after end");

endmodule

// ===== tb/text_command_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// text_command_parser_unit_tb
// Feeds command text one byte per transaction. The bench holds its own parser
// state, which predicts the code and value for each '!', and checks every
// result in order. Covers the reset limit, limit extremes, random limits,
// broken and noisy commands, and back-pressure on both sides.
// ----------------------------------------------------------------------------
module text_command_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcp_pkg::*;

  typedef struct {
    cmd_code_e          code;
    logic [VALUE_W-1:0] value;
  } cmd_result_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic [7:0]         byte_in_i         = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [2:0]         command_code_o;
  logic [VALUE_W-1:0] command_value_o;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic [VALUE_W-1:0] cfg_value_limit_i = '0;

  text_command_parser_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .byte_in_i         (byte_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .command_code_o    (command_code_o),
    .command_value_o   (command_value_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_value_limit_i (cfg_value_limit_i)
  );

  always #5 clk_i = ~clk_i;

  // Parser state mirrored by the bench
  string              keyword_text [KW_COUNT] =
    '{"OpenValve", "CloseValve", "GetLevel", "CommTest", "SetMax", "Start"};
  logic [PROG_W-1:0]  kw_progress [KW_COUNT];
  logic [KW_COUNT-1:0] kw_found;
  logic               search_off;
  logic               hash_seen;
  num_phase_e         num_phase;
  logic               num_negative;
  logic [ACC_W-1:0]   num_acc;
  logic [VALUE_W-1:0] value_limit = LIMIT_RESET;

  cmd_result_t        pending_cmds [$];
  cmd_result_t        head;
  int                 errors     = 0;
  int                 bytes_sent = 0;
  bit                 idle_on    = 1'b1;
  int                 stall_left = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 30) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  function automatic void clear_command();
    foreach (kw_progress[k]) kw_progress[k] = '0;
    kw_found     = '0;
    search_off   = 1'b0;
    hash_seen    = 1'b0;
    num_phase    = NUM_SKIP;
    num_negative = 1'b0;
    num_acc      = '0;
  endfunction

  function automatic void match_keywords(input logic [7:0] c);
    int p;
    int len;
    for (int k = 0; k < KW_COUNT; k++) begin
      p   = kw_progress[k];
      len = keyword_text[k].len();
      if (p >= len) p = 0;
      if (keyword_text[k][p] == c) begin
        p++;
        if (p == len) begin
          kw_found[k] = 1'b1;
          p = 0;
        end
      end else begin
        p = (keyword_text[k][0] == c) ? 1 : 0;
      end
      kw_progress[k] = p[PROG_W-1:0];
    end
  endfunction

  function automatic void read_value(input logic [7:0] c);
    logic [ACC_W+4:0] sum;
    if (num_phase == NUM_DONE) return;
    if (num_phase == NUM_SKIP) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        num_negative = (c == CH_MINUS);
        num_phase    = NUM_DIGITS;
        return;
      end
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      sum       = (ACC_W+5)'(num_acc * 10 + (c - CH_ZERO));
      num_acc   = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
      num_phase = NUM_DIGITS;
    end else begin
      num_phase = NUM_DONE;
    end
  endfunction

  // Advance the mirrored parser by one accepted byte; '!' queues a result.
  function automatic void parse_byte(input logic [7:0] c);
    cmd_result_t r;
    if (c == CH_END) begin
      r.code  = CMD_NONE;
      r.value = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--)
        if (kw_found[k]) r.code = cmd_code_e'(k + 1);
      if ((r.code == CMD_OPEN_VALVE || r.code == CMD_CLOSE_VALVE ||
           r.code == CMD_SET_MAX) && hash_seen && !num_negative)
        r.value = (num_acc > value_limit) ? value_limit : num_acc[VALUE_W-1:0];
      pending_cmds.push_back(r);
      clear_command();
      return;
    end
    if (c == CH_NUL) search_off = 1'b1;
    else if (!search_off) match_keywords(c);
    if (hash_seen) read_value(c);
    else if (c == CH_HASH) hash_seen = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Sender holds off until every queued result has been taken.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [VALUE_W-1:0] v);
    wait_results();
    cfg_valid_i       <= 1'b1;
    cfg_value_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    value_limit = v;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_END) b = CH_SPACE;
    return b;
  endfunction

  // Mostly well-formed commands with random content, some broken or pure noise.
  task automatic send_random_command();
    logic [7:0] q [$];
    string      s;
    int         pos;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 12)) q.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 3)) q.push_back(noise_byte());
      repeat ($urandom_range(1, 2)) begin
        s = keyword_text[$urandom_range(0, KW_COUNT - 1)];
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        if ($urandom_range(0, 9) == 0) begin
          pos = $urandom_range(q.size() - s.len(), q.size() - 1);
          q[pos] = noise_byte();
        end
      end
      if ($urandom_range(0, 15) == 0) q.insert($urandom_range(0, q.size()), CH_NUL);
      if ($urandom_range(0, 7) != 0) begin
        q.push_back(CH_HASH);
        repeat ($urandom_range(0, 2))
          q.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
        case ($urandom_range(0, 3))
          0:       q.push_back(CH_PLUS);
          1:       q.push_back(CH_MINUS);
          default: ;
        endcase
        repeat ($urandom_range(0, 7)) q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0:       q.push_back(CH_HASH);
            1:       q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            default: q.push_back(noise_byte());
          endcase
        end
      end
    end
    q.push_back(CH_END);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic run_commands(input int n_bytes, input bit with_pauses);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      send_random_command();
      if (with_pauses && $urandom_range(0, 19) == 0) wait_results();
    end
  endtask

  // Reset limit, empty command, saturation, whitespace and sign, zero byte.
  task automatic test_directed();
    send_text("!");
    send_text("SetMax#\t+999999!");
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_text("Start#!");
    send_text("OpenValve#-5!");
  endtask

  task automatic test_limit_extremes();
    write_limit('0);
    run_commands(150, 1'b0);
    write_limit('1);
    run_commands(150, 1'b0);
  endtask

  task automatic test_random_limits();
    repeat (4) begin
      write_limit($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 2000)));
      run_commands(150, 1'b1);
    end
  endtask

  task automatic test_pause_until_empty();
    run_commands(50, 1'b0);
    wait_results();
    run_commands(50, 1'b0);
  endtask

  task automatic test_steady_stream();
    write_limit(16'd60000);
    idle_on = 1'b0;
    run_commands(200, 1'b0);
  endtask

  // Result checker and receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected result code %0d value %0d",
                                  command_code_o, command_value_o));
      end else begin
        head = pending_cmds.pop_front();
        if (command_code_o !== head.code)
          report_mismatch($sformatf("code %0d, expected %0d", command_code_o, head.code));
        if (command_value_o !== head.value)
          report_mismatch($sformatf("value %0d, expected %0d", command_value_o, head.value));
      end
    end
    if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 11);
    if (idle_on && stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    clear_command();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limit_extremes();
    test_random_limits();
    test_pause_until_empty();
    test_steady_stream();
    wait_results();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("text_command_parser_unit_tb: done, clean");
    end else begin
      $display("text_command_parser_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("text_command_parser_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tcp_pkg.sv
rtl/core/tcp_kw_bank.sv
rtl/core/tcp_num_reader.sv
rtl/core/text_command_parser_unit.sv
tb/text_command_parser_unit_tb.sv
